### rtl/core/ikvm_pkg.sv
package ikvm_pkg;

  // Stored keys are never negative, so the sign bit is not kept.
  localparam int KeyW = 31;
  localparam int ValW = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CHANGE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NEGATIVE = 3'd1,
    ST_ABSENT   = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    PH_SEARCH = 1'b0,
    PH_APPLY  = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_APPLY  = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  // Token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic             vld;
    phase_t           phase;
    action_t          action;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
    logic             found;
    logic [ValW-1:0]  found_value;
    logic             free_seen;
    logic             claimed;
  } token_t;

endpackage

### rtl/core/integer_key_value_map.sv
// Channel    Direction  Handshake            Fields per beat
// request    in         req_valid/req_stall  action[1:0], key[31:0], value[31:0]
// response   out        rsp_valid/rsp_stall  status[2:0], read_value[31:0]
//
// One request is in flight at a time. A request with a negative key never enters the cell row.
// Any other request sends a search token down the CAPACITY cells, one cell per clock. A
// lookup or a failing request ends after the search pass; a successful insert, remove or
// change sends an apply token after it.
// Reset (rst, synchronous) empties the store at once; no clearing pass runs.
// A stalled response holds in the output register; the next result and the request side wait.
module integer_key_value_map #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [31:0] read_value
);

  ikvm_pkg::state_t  state;
  ikvm_pkg::state_t  state_next;

  // Request held for the apply pass.
  ikvm_pkg::action_t         req_action;
  logic [ikvm_pkg::KeyW-1:0] req_key;
  logic [ikvm_pkg::ValW-1:0] req_value;

  // Result held until the output register is free.
  ikvm_pkg::status_t         res_status;
  ikvm_pkg::status_t         res_status_next;
  logic [ikvm_pkg::ValW-1:0] res_value;
  logic [ikvm_pkg::ValW-1:0] res_value_next;
  logic                      load_res;
  logic                      load_out;

  // Token chain: tok[0] is the launch register, tok[CAPACITY] leaves the row.
  ikvm_pkg::token_t tok [CAPACITY+1];
  ikvm_pkg::token_t launch_next;
  ikvm_pkg::token_t tail;

  logic accept;

  assign req_stall = (state != ikvm_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign tail      = tok[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ikvm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // Next state, launch token and result decisions.
  always_comb begin
    state_next      = state;
    launch_next     = '0;
    load_res        = 1'b0;
    load_out        = 1'b0;
    res_status_next = ikvm_pkg::ST_DONE;
    res_value_next  = '0;
    case (state)
      ikvm_pkg::S_IDLE: begin
        if (req_valid) begin
          if (key[31]) begin
            // Negative keys never touch the store.
            load_res        = 1'b1;
            res_status_next = ikvm_pkg::ST_NEGATIVE;
            state_next      = ikvm_pkg::S_FINISH;
          end else begin
            launch_next.vld    = 1'b1;
            launch_next.phase  = ikvm_pkg::PH_SEARCH;
            launch_next.action = ikvm_pkg::action_t'(action);
            launch_next.key    = key[ikvm_pkg::KeyW-1:0];
            launch_next.value  = value;
            state_next         = ikvm_pkg::S_SEARCH;
          end
        end
      end
      ikvm_pkg::S_SEARCH: begin
        if (tail.vld) begin
          load_res           = 1'b1;
          state_next         = ikvm_pkg::S_FINISH;
          launch_next.phase  = ikvm_pkg::PH_APPLY;
          launch_next.action = req_action;
          launch_next.key    = req_key;
          launch_next.value  = req_value;
          if (req_action == ikvm_pkg::ACT_INSERT) begin
            if (tail.found) begin
              res_status_next = ikvm_pkg::ST_PRESENT;
            end else if (!tail.free_seen) begin
              res_status_next = ikvm_pkg::ST_FULL;
            end else begin
              launch_next.vld = 1'b1;
              state_next      = ikvm_pkg::S_APPLY;
            end
          end else if (!tail.found) begin
            res_status_next = ikvm_pkg::ST_ABSENT;
          end else if (req_action == ikvm_pkg::ACT_LOOKUP) begin
            res_value_next = tail.found_value;
          end else begin
            // Remove and change both write the store; change returns the old value.
            if (req_action == ikvm_pkg::ACT_CHANGE) begin
              res_value_next = tail.found_value;
            end
            launch_next.vld = 1'b1;
            state_next      = ikvm_pkg::S_APPLY;
          end
        end
      end
      ikvm_pkg::S_APPLY: begin
        if (tail.vld) begin
          state_next = ikvm_pkg::S_FINISH;
        end
      end
      ikvm_pkg::S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = ikvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ikvm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ikvm_pkg::S_IDLE;
      tok[0]    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      tok[0] <= launch_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= ikvm_pkg::action_t'(action);
      req_key    <= key[ikvm_pkg::KeyW-1:0];
      req_value  <= value;
    end
    if (load_res) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end
    if (load_out) begin
      status     <= res_status;
      read_value <= res_value;
    end
  end

endmodule

### rtl/core/ikvm_cell.sv
module ikvm_cell (
  input  logic             clk,
  input  logic             rst,
  input  ikvm_pkg::token_t tok_in,
  output ikvm_pkg::token_t tok_out
);

  logic                      valid;
  logic [ikvm_pkg::KeyW-1:0] entry_key;
  logic [ikvm_pkg::ValW-1:0] entry_value;
  ikvm_pkg::token_t          tok_next;
  logic                      hit;
  logic                      apply;
  logic                      claim;

  assign hit   = valid && (entry_key == tok_in.key);
  assign apply = tok_in.vld && (tok_in.phase == ikvm_pkg::PH_APPLY);
  // The first free cell that an insert token meets takes the entry.
  assign claim = apply && (tok_in.action == ikvm_pkg::ACT_INSERT) &&
                 !valid && !tok_in.claimed;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.phase == ikvm_pkg::PH_SEARCH) begin
      tok_next.found     = tok_in.found | hit;
      tok_next.free_seen = tok_in.free_seen | !valid;
      if (hit) begin
        tok_next.found_value = entry_value;
      end
    end else begin
      tok_next.claimed = tok_in.claimed | claim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (claim) begin
        valid <= 1'b1;
      end else if (apply && hit && (tok_in.action == ikvm_pkg::ACT_REMOVE)) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      entry_key   <= tok_in.key;
      entry_value <= tok_in.value;
    end else if (apply && hit && (tok_in.action == ikvm_pkg::ACT_CHANGE)) begin
      entry_value <= tok_in.value;
    end
  end

endmodule

### rtl/core/ikvm_checker.sv
module ikvm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [2:0]  status,
  input logic [31:0] read_value
);

  // A held response beat stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(read_value))
    else $error("response beat changed while stalled");

  // A failed request never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ikvm_pkg::ST_DONE) |-> (read_value == '0))
    else $error("nonzero read_value on a failed request");

  // The block works on one request at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in flight");

  // Reset leaves no response pending and the request side free.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("response or busy state survived reset");

endmodule

bind integer_key_value_map ikvm_checker u_ikvm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .read_value(read_value)
);
